/* hw/rtl/wbps_pkg.sv */
package wbps_pkg;

	// defaults for the top-level parameters
	localparam int DEF_PATTERN_BYTES = 16;
	localparam int DEF_OFFSET_BITS   = 32;

	// fixed sizes
	localparam int WINDOW_DEPTH   = 16;
	localparam int DATA_W         = 8;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int MASK_W         = 16;
	localparam int PLEN_W         = 5;
	localparam int MATCH_OFFSET_W = 32;
	localparam int LEN_M1_W       = 4;
	localparam int QUEUE_DEPTH    = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_WILDCARD_MASK  = 2'd2,
		CFG_PATTERN_LENGTH = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic                      found;
		logic [MATCH_OFFSET_W-1:0] match_offset;
	} out_item_t;

	typedef struct packed {
		logic [2*CFG_DATA_W-1:0] pattern;
		logic [MASK_W-1:0]       wildcard_mask;
		logic [PLEN_W-1:0]       pattern_length;
	} cfg_t;

	// control part of a result record handed from front to back
	typedef struct packed {
		logic                found;
		logic                sat;
		logic [LEN_M1_W-1:0] len_m1;
	} rec_ctl_t;

endpackage

/* hw/rtl/wbps_front.sv */
module wbps_front #(
	parameter int PATTERN_BYTES = wbps_pkg::DEF_PATTERN_BYTES,
	parameter int OFFSET_BITS   = wbps_pkg::DEF_OFFSET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbps_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wbps_pkg::in_item_t   in_data,
	input  logic                 q_full,
	output logic                 push,
	output wbps_pkg::rec_ctl_t   push_ctl,
	output logic [OFFSET_BITS-1:0] push_idx
);

	localparam int MaxLen = (PATTERN_BYTES < wbps_pkg::WINDOW_DEPTH) ?
		PATTERN_BYTES : wbps_pkg::WINDOW_DEPTH;
	localparam int LenW = $clog2(MaxLen + 1);
	localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

	logic [wbps_pkg::DATA_W-1:0] win_q [MaxLen];
	logic [wbps_pkg::DATA_W-1:0] win_n [MaxLen];
	logic [LenW-1:0]             fill_q;
	logic [LenW-1:0]             fill_n;
	logic [OFFSET_BITS-1:0]      seen_q;
	logic                        done_q;
	logic [LenW-1:0]             eff_len;
	logic [IdxW-1:0]             len_m1;
	logic [IdxW-1:0]             sel;
	logic                        hit;
	logic                        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// effective pattern length: zero acts as one, clipped to the window
	always_comb begin
		if (cfg.pattern_length == '0) begin
			eff_len = LenW'(1);
		end else if (cfg.pattern_length > wbps_pkg::PLEN_W'(MaxLen)) begin
			eff_len = LenW'(MaxLen);
		end else begin
			eff_len = cfg.pattern_length[LenW-1:0];
		end
	end

	assign len_m1 = IdxW'(eff_len - LenW'(1));
	assign fill_n = (fill_q == LenW'(MaxLen)) ? fill_q : fill_q + LenW'(1);

	// window after taking the new byte, entry 0 newest
	always_comb begin
		win_n[0] = in_data.data_byte;
		for (int i = 1; i < MaxLen; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	// masked compare, pattern byte j against window entry len-1-j
	always_comb begin
		hit = (fill_n >= eff_len);
		sel = '0;
		for (int j = 0; j < MaxLen; j++) begin
			sel = len_m1 - IdxW'(j);
			if (IdxW'(j) <= len_m1 && !cfg.wildcard_mask[j]) begin
				if (win_n[sel] != cfg.pattern[8*j +: 8]) begin
					hit = 1'b0;
				end
			end
		end
	end

	assign push            = accept && !done_q && (hit || in_data.last_byte);
	assign push_ctl.found  = hit;
	assign push_ctl.sat    = (seen_q == '1);
	assign push_ctl.len_m1 = wbps_pkg::LEN_M1_W'(len_m1);
	assign push_idx        = seen_q;

	// window payload needs no reset, fill count guards it
	always_ff @(posedge clk) begin
		if (accept && !done_q) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				fill_q <= '0;
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				if (seen_q != '1) begin
					seen_q <= seen_q + OFFSET_BITS'(1);
				end
				if (!done_q) begin
					fill_q <= fill_n;
					if (hit) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LenW'(MaxLen))
		else $error("window fill beyond depth");

	a_match_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_ctl.found && !in_data.last_byte) |=> done_q)
		else $error("match not recorded");

	a_no_push_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !push)
		else $error("second result in one scan");

endmodule

/* hw/rtl/wbps_queue.sv */
module wbps_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = wbps_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_pop;

	assign full     = (cnt_q == CntW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("queue count out of range");

endmodule

/* hw/rtl/wbps_back.sv */
module wbps_back #(
	parameter int OFFSET_BITS = wbps_pkg::DEF_OFFSET_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  wbps_pkg::rec_ctl_t     q_ctl,
	input  logic [OFFSET_BITS-1:0] q_idx,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output wbps_pkg::out_item_t    out_data
);

	localparam int ExtW = (OFFSET_BITS > wbps_pkg::MATCH_OFFSET_W) ?
		OFFSET_BITS : wbps_pkg::MATCH_OFFSET_W;

	logic                   out_valid_q;
	wbps_pkg::out_item_t    out_q;
	logic [OFFSET_BITS-1:0] off;
	logic [ExtW-1:0]        off_ext;

	// start offset: saturated counter reports all ones
	assign off     = q_ctl.sat ? '1 : q_idx - OFFSET_BITS'(q_ctl.len_m1);
	assign off_ext = ExtW'(off);

	assign pop       = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.found        <= q_ctl.found;
			out_q.match_offset <= q_ctl.found ?
				off_ext[wbps_pkg::MATCH_OFFSET_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.match_offset == '0))
		else $error("not-found result with nonzero offset");

endmodule

/* hw/rtl/wildcard_byte_pattern_search_core.sv */
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_item_t  (data_byte, last_byte)
// out     | output    | out_valid/out_stall | out_item_t (found, match_offset)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (64 bits)
//
// one image byte per cycle while in_stall is low; results go via the queue to out
// the front compares the newest pattern-length window bytes in the cycle the byte arrives
// results wait in a four-entry queue; in_stall rises only when it is full
// out is an output register; a stalled result holds up input only once the queue is full
// arst_n clears the scan state and the registers to 0, 0, 0 and length 1
module wildcard_byte_pattern_search_core #(
	parameter int PATTERN_BYTES = wbps_pkg::DEF_PATTERN_BYTES,
	parameter int OFFSET_BITS   = wbps_pkg::DEF_OFFSET_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wbps_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wbps_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CtlW = $bits(wbps_pkg::rec_ctl_t);
	localparam int RecW = CtlW + OFFSET_BITS;

	// configuration registers
	wbps_pkg::cfg_t cfg_q;

	// front to queue
	logic                   push;
	wbps_pkg::rec_ctl_t     push_ctl;
	logic [OFFSET_BITS-1:0] push_idx;
	logic [RecW-1:0]        push_rec;

	// queue to back
	logic                   q_full;
	logic                   q_empty;
	logic                   pop;
	logic [RecW-1:0]        pop_rec;
	wbps_pkg::rec_ctl_t     q_ctl;
	logic [OFFSET_BITS-1:0] q_idx;

	// writes are always taken, one transaction per cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.wildcard_mask  <= '0;
			cfg_q.pattern_length <= wbps_pkg::PLEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (wbps_pkg::cfg_reg_e'(cfg_index))
				wbps_pkg::CFG_PATTERN_LOW: begin
					cfg_q.pattern[wbps_pkg::CFG_DATA_W-1:0] <= cfg_data;
				end
				wbps_pkg::CFG_PATTERN_HIGH: begin
					cfg_q.pattern[2*wbps_pkg::CFG_DATA_W-1:wbps_pkg::CFG_DATA_W] <= cfg_data;
				end
				wbps_pkg::CFG_WILDCARD_MASK: begin
					cfg_q.wildcard_mask <= cfg_data[wbps_pkg::MASK_W-1:0];
				end
				wbps_pkg::CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[wbps_pkg::PLEN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: window, counters, compare; emits a record per result
	wbps_front #(
		.PATTERN_BYTES(PATTERN_BYTES),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_full  (q_full),
		.push    (push),
		.push_ctl(push_ctl),
		.push_idx(push_idx)
	);

	assign push_rec = {push_ctl, push_idx};

	// short result queue decoupling scan from delivery
	wbps_queue #(
		.WIDTH(RecW),
		.DEPTH(wbps_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_rec),
		.pop      (pop),
		.pop_data (pop_rec),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign q_ctl = wbps_pkg::rec_ctl_t'(pop_rec[RecW-1:OFFSET_BITS]);
	assign q_idx = pop_rec[OFFSET_BITS-1:0];

	// back: offset arithmetic and the output register
	wbps_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_ctl    (q_ctl),
		.q_idx    (q_idx),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
